>>> rtl/hsvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvc_pkg: shared types and constants for the HSV to RGB converter
// Word layouts, sector codes and fixed widths used by every stage.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    // Fixed field widths
    localparam int unsigned HUE_W  = 9;
    localparam int unsigned SAT_W  = 8;
    localparam int unsigned V_W    = 14;
    localparam int unsigned CHAN_W = 8;

    // Arithmetic constants
    localparam int unsigned HUE_MAX    = 359;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned CHAN_MAX   = 255;
    localparam int unsigned CHAN_SPAN  = CHAN_MAX * SECTOR_DEG;   // 15300
    localparam int unsigned NUM_SECTORS = 6;

    localparam int unsigned VALUE_FULL_SCALE_DEF = 10000;

    // Coefficients are at most 15300, numerators at most 16383 * 15300
    localparam int unsigned COEF_W = 14;
    localparam int unsigned FRAC_W = 6;
    localparam int unsigned NUM_W  = V_W + COEF_W;
    localparam int unsigned Q_W    = CHAN_W;

    // Four parallel lanes, all divided by 60 * full scale
    localparam int unsigned NUM_LANES = 4;
    localparam int unsigned LANE_TOP  = 0;
    localparam int unsigned LANE_P    = 1;
    localparam int unsigned LANE_Q    = 2;
    localparam int unsigned LANE_T    = 3;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] saturation;
        logic [V_W-1:0]   brightness_value;
    } t_hsv_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_word;

    typedef struct packed {
        t_sector           sector;
        logic [V_W-1:0]    v;
        logic [COEF_W-1:0] coef_p;
        logic [COEF_W-1:0] coef_q;
        logic [COEF_W-1:0] coef_t;
    } t_coef_word;

    typedef struct packed {
        t_sector                          sector;
        logic [NUM_LANES-1:0][NUM_W-1:0]  num;
    } t_num_word;

    typedef struct packed {
        t_sector                          sector;
        logic [NUM_LANES-1:0][Q_W-1:0]    quo;
    } t_quo_word;

endpackage
`default_nettype wire

>>> rtl/hsvc_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvc_prep: input clamp, sector split and channel coefficients
// Two register stages: clamp and sector/fraction, then the s*f products.
// ----------------------------------------------------------------------------
module hsvc_prep #(
    parameter int unsigned VALUE_FULL_SCALE = hsvc_pkg::VALUE_FULL_SCALE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  hsvc_pkg::t_hsv_word    i_hsv,
    output logic                   o_valid,
    input  wire                    i_ready,
    output hsvc_pkg::t_coef_word   o_coef
);
    import hsvc_pkg::*;

    localparam int unsigned V_LIM =
        (VALUE_FULL_SCALE < (2**V_W) - 1) ? VALUE_FULL_SCALE : (2**V_W) - 1;

    logic                 r_s1_vld;
    t_sector              r_s1_sec;
    logic [FRAC_W-1:0]    r_s1_frac;
    logic [SAT_W-1:0]     r_s1_sat;
    logic [V_W-1:0]       r_s1_v;
    logic                 r_s2_vld;
    t_coef_word           r_s2;

    logic                 w_en1;
    logic                 w_en2;
    logic [HUE_W-1:0]     w_hue;
    logic [HUE_W-1:0]     w_base;
    t_sector              n_s1_sec;
    logic [FRAC_W-1:0]    n_s1_frac;
    logic [V_W-1:0]       n_s1_v;
    logic [COEF_W-1:0]    w_prod_f;
    logic [COEF_W-1:0]    w_prod_g;
    t_coef_word           n_s2;

    assign w_en2   = !r_s2_vld || i_ready;
    assign w_en1   = !r_s1_vld || w_en2;
    assign o_ready = w_en1;

    // clamp, then sector by threshold compare
    always_comb begin
        w_hue = (i_hsv.hue > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : i_hsv.hue;
        n_s1_sec = SEC_RED;
        w_base   = '0;
        for (int k = 1; k < NUM_SECTORS; k++) begin
            if (w_hue >= HUE_W'(k * SECTOR_DEG)) begin
                n_s1_sec = t_sector'(3'(k));
                w_base   = HUE_W'(k * SECTOR_DEG);
            end
        end
        n_s1_frac = FRAC_W'(w_hue - w_base);
        n_s1_v    = (i_hsv.brightness_value > V_W'(V_LIM)) ? V_W'(V_LIM)
                                                           : i_hsv.brightness_value;
    end

    // coefficients scaled to a common divisor of 60 * full scale
    always_comb begin
        w_prod_f = COEF_W'({{(COEF_W-SAT_W){1'b0}}, r_s1_sat}
                           * {{(COEF_W-FRAC_W){1'b0}}, r_s1_frac});
        w_prod_g = COEF_W'({{(COEF_W-SAT_W){1'b0}}, r_s1_sat}
                           * (COEF_W'(SECTOR_DEG) - {{(COEF_W-FRAC_W){1'b0}}, r_s1_frac}));
        n_s2.sector = r_s1_sec;
        n_s2.v      = r_s1_v;
        n_s2.coef_p = COEF_W'({{(COEF_W-SAT_W){1'b0}}, SAT_W'(CHAN_MAX) - r_s1_sat}
                              * COEF_W'(SECTOR_DEG));
        n_s2.coef_q = COEF_W'(CHAN_SPAN) - w_prod_f;
        n_s2.coef_t = COEF_W'(CHAN_SPAN) - w_prod_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_vld <= i_valid;
            end
            if (w_en2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_s1_sec  <= n_s1_sec;
            r_s1_frac <= n_s1_frac;
            r_s1_sat  <= i_hsv.saturation;
            r_s1_v    <= n_s1_v;
        end
        if (w_en2 && r_s1_vld) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_s2_vld;
    assign o_coef  = r_s2;

endmodule
`default_nettype wire

>>> rtl/hsvc_mult.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvc_mult: brightness times coefficient, four lanes
// One register stage of 14x14 multipliers.
// ----------------------------------------------------------------------------
module hsvc_mult (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  hsvc_pkg::t_coef_word   i_coef,
    output logic                   o_valid,
    input  wire                    i_ready,
    output hsvc_pkg::t_num_word    o_num
);
    import hsvc_pkg::*;

    logic        r_vld;
    t_num_word   r_num;
    logic        w_en;
    t_num_word   n_num;
    logic [NUM_W-1:0] w_v;

    assign w_en    = !r_vld || i_ready;
    assign o_ready = w_en;

    always_comb begin
        w_v = NUM_W'(i_coef.v);
        n_num.sector          = i_coef.sector;
        n_num.num[LANE_TOP]   = w_v * NUM_W'(CHAN_SPAN);
        n_num.num[LANE_P]     = w_v * NUM_W'(i_coef.coef_p);
        n_num.num[LANE_Q]     = w_v * NUM_W'(i_coef.coef_q);
        n_num.num[LANE_T]     = w_v * NUM_W'(i_coef.coef_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_num <= n_num;
        end
    end

    assign o_valid = r_vld;
    assign o_num   = r_num;

endmodule
`default_nettype wire

>>> rtl/hsvc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvc_div: pipelined restoring divider by 60 * full scale
// One quotient bit per stage, MSB first, four lanes side by side.
// ----------------------------------------------------------------------------
module hsvc_div #(
    parameter int unsigned VALUE_FULL_SCALE = hsvc_pkg::VALUE_FULL_SCALE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  hsvc_pkg::t_num_word    i_num,
    output logic                   o_valid,
    input  wire                    i_ready,
    output hsvc_pkg::t_quo_word    o_quo
);
    import hsvc_pkg::*;

    localparam int unsigned DEN   = SECTOR_DEG * VALUE_FULL_SCALE;
    localparam int unsigned DEN_W = $clog2(DEN + 1);
    localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W-1:0]                          r_vld;
    t_sector                                 r_sec [Q_W];
    logic [NUM_LANES-1:0][CMP_W-1:0]         r_rem [Q_W];
    logic [NUM_LANES-1:0][Q_W-1:0]           r_quo [Q_W];

    logic [Q_W-1:0]                          w_en;
    logic [Q_W-1:0]                          w_in_vld;
    t_sector                                 w_in_sec [Q_W];
    logic [NUM_LANES-1:0][CMP_W-1:0]         w_in_rem [Q_W];
    logic [NUM_LANES-1:0][Q_W-1:0]           w_in_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int unsigned BIT = Q_W - 1 - k;
        localparam logic [CMP_W-1:0] TRIAL = CMP_W'(DEN) << BIT;

        logic [NUM_LANES-1:0][CMP_W-1:0] n_rem;
        logic [NUM_LANES-1:0][Q_W-1:0]   n_quo;

        if (k == 0) begin : g_head
            always_comb begin
                w_in_vld[k] = i_valid;
                w_in_sec[k] = i_num.sector;
                for (int l = 0; l < NUM_LANES; l++) begin
                    w_in_rem[k][l] = CMP_W'(i_num.num[l]);
                    w_in_quo[k][l] = '0;
                end
            end
        end else begin : g_link
            always_comb begin
                w_in_vld[k] = r_vld[k-1];
                w_in_sec[k] = r_sec[k-1];
                w_in_rem[k] = r_rem[k-1];
                w_in_quo[k] = r_quo[k-1];
            end
        end

        if (k == Q_W - 1) begin : g_tail
            assign w_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end

        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                if (w_in_rem[k][l] >= TRIAL) begin
                    n_rem[l] = w_in_rem[k][l] - TRIAL;
                    n_quo[l] = w_in_quo[k][l] | (Q_W'(1) << BIT);
                end else begin
                    n_rem[l] = w_in_rem[k][l];
                    n_quo[l] = w_in_quo[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_vld[k] <= w_in_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k] && w_in_vld[k]) begin
                r_sec[k] <= w_in_sec[k];
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_ready      = w_en[0];
    assign o_valid      = r_vld[Q_W-1];
    assign o_quo.sector = r_sec[Q_W-1];
    assign o_quo.quo    = r_quo[Q_W-1];

endmodule
`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: pipelined HSV to 8-bit RGB colour conversion
//
// Input channel: i_valid / o_ready carrying i_hsv (hue, saturation,
// brightness_value). Hue above 359 is taken as 359; brightness above
// VALUE_FULL_SCALE is taken as full scale. Output channel: o_valid /
// i_ready carrying o_rgb (red, green, blue). One output word per input word,
// in order.
// From acceptance to o_valid a word passes two prep stages (clamp
// and sector split, then s*f coefficients), one multiply stage, eight
// divider stages producing one quotient bit each, and the output register.
// Throughput is one word per cycle while i_ready allows; no loop feeds back,
// so the divider depth sets latency only.
// Every stage has its own valid bit and load enable, so bubbles close up
// while the receiver stalls and o_ready stays high until every stage holds
// a word. Synchronous active-low reset clears all valid bits; data registers
// are not reset. Zero saturation needs no special path: p, q and t all come
// out equal to top.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
    parameter int unsigned VALUE_FULL_SCALE = hsvc_pkg::VALUE_FULL_SCALE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  hsvc_pkg::t_hsv_word    i_hsv,
    output logic                   o_valid,
    input  wire                    i_ready,
    output hsvc_pkg::t_rgb_word    o_rgb
);
    import hsvc_pkg::*;

    logic        w_prep_vld;
    logic        w_prep_rdy;
    t_coef_word  w_coef;
    logic        w_mult_vld;
    logic        w_mult_rdy;
    t_num_word   w_num;
    logic        w_div_vld;
    logic        w_div_rdy;
    t_quo_word   w_quo;

    logic        r_out_vld;
    t_rgb_word   r_out;
    t_rgb_word   n_out;
    logic        w_out_en;

    hsvc_prep #(
        .VALUE_FULL_SCALE (VALUE_FULL_SCALE)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (w_prep_vld),
        .i_ready (w_prep_rdy),
        .o_coef  (w_coef)
    );

    hsvc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_vld),
        .o_ready (w_prep_rdy),
        .i_coef  (w_coef),
        .o_valid (w_mult_vld),
        .i_ready (w_mult_rdy),
        .o_num   (w_num)
    );

    hsvc_div #(
        .VALUE_FULL_SCALE (VALUE_FULL_SCALE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mult_vld),
        .o_ready (w_mult_rdy),
        .i_num   (w_num),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_quo   (w_quo)
    );

    assign w_out_en  = !r_out_vld || i_ready;
    assign w_div_rdy = w_out_en;

    // sector picks the channel order
    always_comb begin
        case (w_quo.sector)
            SEC_RED: begin
                n_out.red   = w_quo.quo[LANE_TOP];
                n_out.green = w_quo.quo[LANE_T];
                n_out.blue  = w_quo.quo[LANE_P];
            end
            SEC_YELLOW: begin
                n_out.red   = w_quo.quo[LANE_Q];
                n_out.green = w_quo.quo[LANE_TOP];
                n_out.blue  = w_quo.quo[LANE_P];
            end
            SEC_GREEN: begin
                n_out.red   = w_quo.quo[LANE_P];
                n_out.green = w_quo.quo[LANE_TOP];
                n_out.blue  = w_quo.quo[LANE_T];
            end
            SEC_CYAN: begin
                n_out.red   = w_quo.quo[LANE_P];
                n_out.green = w_quo.quo[LANE_Q];
                n_out.blue  = w_quo.quo[LANE_TOP];
            end
            SEC_BLUE: begin
                n_out.red   = w_quo.quo[LANE_T];
                n_out.green = w_quo.quo[LANE_P];
                n_out.blue  = w_quo.quo[LANE_TOP];
            end
            default: begin
                n_out.red   = w_quo.quo[LANE_TOP];
                n_out.green = w_quo.quo[LANE_P];
                n_out.blue  = w_quo.quo[LANE_Q];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && w_div_vld) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rgb   = r_out;

endmodule
`default_nettype wire

>>> rtl/hsvc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsvc_checker: port-level checks for the HSV to RGB converter
// Reset, back-pressure and ready behaviour seen from the top-level ports.
// ----------------------------------------------------------------------------
module hsvc_checker (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire                    o_ready,
    input  hsvc_pkg::t_hsv_word    i_hsv,
    input  wire                    o_valid,
    input  wire                    i_ready,
    input  hsvc_pkg::t_rgb_word    o_rgb
);
    import hsvc_pkg::*;

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // empty output stage lets every stage load
    a_ready_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with output stage empty");

    // a taken output frees the whole chain
    a_ready_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output is being taken");

    // stalled output word holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rgb))
        else $error("output word changed under stall");

    // waiting input word holds until taken
    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_hsv))
        else $error("input word changed while waiting");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_hsv   (i_hsv),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rgb   (o_rgb)
);
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for hsv_to_rgb_converter
// Drives HSV words through the valid/ready input, predicts every RGB word
// with an integer model of the conversion and checks the output stream in
// order, under random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import hsvc_pkg::*;

    localparam int unsigned FULL_SCALE      = VALUE_FULL_SCALE_DEF;
    localparam int          HOLD_OFF_CYCLES = 80;   // well beyond pipeline depth
    localparam int          DRAIN_CYCLES    = 30;   // margin beyond the pipeline latency
    localparam int          RANDOM_PER_PHASE = 610;
    localparam int          MAX_REPORTS     = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the RGB word for each accepted HSV word and checks
    // output words against the oldest prediction.
    // ------------------------------------------------------------------------
    class rgb_scoreboard;
        t_rgb_word rgb_due[$];
        int        failures;

        function new();
            failures = 0;
        endfunction

        // Exact integer form of the conversion; every division truncates.
        function t_rgb_word convert_colour(t_hsv_word w);
            int unsigned h;
            int unsigned s;
            int unsigned v;
            int unsigned f;
            int unsigned top;
            int unsigned p;
            int unsigned q;
            int unsigned t;
            t_sector     sec;
            t_rgb_word   rgb;
            h = w.hue;
            s = w.saturation;
            v = w.brightness_value;
            if (h > HUE_MAX) h = HUE_MAX;
            if (v > FULL_SCALE) v = FULL_SCALE;
            top = v * CHAN_MAX / FULL_SCALE;
            sec = t_sector'(h / SECTOR_DEG);
            f   = h % SECTOR_DEG;
            p   = v * (CHAN_MAX - s) / FULL_SCALE;
            q   = v * (CHAN_SPAN - s * f) / (SECTOR_DEG * FULL_SCALE);
            t   = v * (CHAN_SPAN - s * (SECTOR_DEG - f)) / (SECTOR_DEG * FULL_SCALE);
            if (s == 0) begin
                rgb = '{red: top[7:0], green: top[7:0], blue: top[7:0]};
            end else begin
                case (sec)
                    SEC_RED:    rgb = '{red: top[7:0], green: t[7:0],   blue: p[7:0]};
                    SEC_YELLOW: rgb = '{red: q[7:0],   green: top[7:0], blue: p[7:0]};
                    SEC_GREEN:  rgb = '{red: p[7:0],   green: top[7:0], blue: t[7:0]};
                    SEC_CYAN:   rgb = '{red: p[7:0],   green: q[7:0],   blue: top[7:0]};
                    SEC_BLUE:   rgb = '{red: t[7:0],   green: p[7:0],   blue: top[7:0]};
                    default:    rgb = '{red: top[7:0], green: p[7:0],   blue: q[7:0]};
                endcase
            end
            return rgb;
        endfunction

        function void note_pixel(t_hsv_word w);
            rgb_due.push_back(convert_colour(w));
        endfunction

        function void check_pixel(t_rgb_word got);
            t_rgb_word want;
            if (rgb_due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected output word r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue);
                return;
            end
            want = rgb_due.pop_front();
            if (got.red != want.red || got.green != want.green
                    || got.blue != want.blue) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return rgb_due.size();
        endfunction

        function int faults();
            return failures + rgb_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_hsv_word i_hsv;
    logic      o_valid;
    logic      i_ready;
    t_rgb_word o_rgb;

    rgb_scoreboard book;

    int send_idle_pct;   // chance in a hundred of a gap before each input word
    int recv_idle_pct;   // chance in a hundred of i_ready low in a cycle
    bit hold_off_req;    // asks the receiver for one long stall

    hsv_to_rgb_converter #(
        .VALUE_FULL_SCALE (FULL_SCALE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop should the pipeline hang
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random i_ready at each falling edge, or a long hold-off on
    // request so the pipeline fills and drops o_ready.
    // ------------------------------------------------------------------------
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
                    i_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Output monitor: a word moves when o_valid and i_ready meet at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_pixel(o_rgb);
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic t_hsv_word make_hsv(int unsigned h, int unsigned s, int unsigned v);
        t_hsv_word w;
        w.hue              = h[HUE_W-1:0];
        w.saturation       = s[SAT_W-1:0];
        w.brightness_value = v[V_W-1:0];
        return w;
    endfunction

    // Mostly in-range colours, with a share of clamped hue/brightness,
    // sector edges and raw full-width noise.
    function automatic t_hsv_word random_hsv();
        t_hsv_word w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                w = make_hsv($urandom_range(0, HUE_MAX), $urandom_range(0, CHAN_MAX),
                             $urandom_range(0, FULL_SCALE));
            6:
                w = make_hsv($urandom_range(HUE_MAX + 1, 511), $urandom_range(0, CHAN_MAX),
                             $urandom_range(0, 16383));
            7:
                w = make_hsv($urandom_range(0, NUM_SECTORS - 1) * SECTOR_DEG
                                 + ($urandom_range(0, 1) ? SECTOR_DEG - 1 : 0),
                             $urandom_range(0, 1) ? CHAN_MAX : 0,
                             $urandom_range(0, FULL_SCALE));
            8:
                w = make_hsv($urandom_range(0, HUE_MAX), $urandom_range(0, CHAN_MAX),
                             $urandom_range(FULL_SCALE, 16383));
            default:
                w = t_hsv_word'($urandom);
        endcase
        return w;
    endfunction

    // Offer one word from a falling edge and hold it until accepted
    task automatic send_hsv(input t_hsv_word w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_hsv   <= w;
        do @(posedge i_clk); while (!o_ready);
        book.note_pixel(w);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_hsv(random_hsv());
    endtask

    initial begin
        t_hsv_word corner_words[$];

        book          = new();
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_hsv         = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 55;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Corners: black, white, hue edges and clamping, grey, brightness
        // saturation, smallest non-zero values
        corner_words.push_back(make_hsv(0, 0, 0));
        corner_words.push_back(make_hsv(0, 255, 10000));
        corner_words.push_back(make_hsv(359, 255, 10000));
        corner_words.push_back(make_hsv(360, 255, 10000));
        corner_words.push_back(make_hsv(511, 255, 16383));
        corner_words.push_back(make_hsv(59, 255, 10000));
        corner_words.push_back(make_hsv(60, 255, 10000));
        corner_words.push_back(make_hsv(30, 0, 10000));
        corner_words.push_back(make_hsv(200, 0, 16383));
        corner_words.push_back(make_hsv(100, 128, 10001));
        corner_words.push_back(make_hsv(300, 1, 1));
        corner_words.push_back(make_hsv(240, 255, 9999));
        corner_words.push_back(make_hsv(180, 200, 5000));
        corner_words.push_back(make_hsv(511, 0, 0));
        corner_words.push_back(make_hsv(120, 255, 16383));
        // One mid-sector colour per sector
        for (int k = 0; k < NUM_SECTORS; k++)
            corner_words.push_back(make_hsv(30 + k * SECTOR_DEG, 170, 7777));
        foreach (corner_words[i])
            send_hsv(corner_words[i]);

        // Phase 1: sender idles a little, receiver a lot
        send_random(RANDOM_PER_PHASE);

        // Phase 2: the other way round
        send_idle_pct = 55;
        recv_idle_pct = 21;
        send_random(RANDOM_PER_PHASE);

        // Phase 3: full rate both ways, with one long receiver stall
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(100);
        hold_off_req = 1'b1;
        send_random(RANDOM_PER_PHASE - 100);

        @(negedge i_clk);
        i_valid <= 1'b0;

        while (book.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.faults() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
